[hdl/bise_pkg.sv]
// ----------------------------------------------------------------------------
// bise_pkg: shared types for the binary insertion sort engine
// Word layouts of the input and result channels.
// ----------------------------------------------------------------------------
package bise_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_in;
  } bise_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;
  } bise_out_t;

endpackage

[hdl/bise_mem.sv]
// ----------------------------------------------------------------------------
// bise_mem: sorted store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module bise_mem
  import bise_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic signed [VALUE_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic signed [VALUE_W-1:0] rd_data_o
);

  logic signed [VALUE_W-1:0] mem_q [DEPTH];
  logic signed [VALUE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // hold read data between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/bise_ctrl.sv]
// ----------------------------------------------------------------------------
// bise_ctrl: insertion sequencer
// Binary search over the store with one shared comparator, shift of the
// upper entries one at a time (read, then write back), then readout of the list.
// ----------------------------------------------------------------------------
module bise_ctrl
  import bise_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bise_in_t                  in_word_i,
  input  logic                      slot_free_i,
  output logic                      out_load_o,
  output bise_out_t                 out_word_o,
  output logic                      wr_en_o,
  output logic [AW-1:0]             wr_addr_o,
  output logic signed [VALUE_W-1:0] wr_data_o,
  output logic                      rd_en_o,
  output logic [AW-1:0]             rd_addr_o,
  input  logic signed [VALUE_W-1:0] rd_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  state_e                    state_q;
  logic [CW-1:0]             fill_q;
  logic                      dropped_q;
  logic [CW-1:0]             lo_q, hi_q, idx_q;
  logic [AW-1:0]             mid_q;
  logic signed [VALUE_W-1:0] val_q;
  logic                      last_q;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] idx_inc;
  logic          key_less;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[CW:1];
  assign idx_dec  = idx_q - CW'(1);
  assign idx_inc  = idx_q + CW'(1);
  // shared comparator: store entry below the incoming value
  assign key_less = rd_data_i < val_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    wr_en_o    = 1'b0;
    wr_addr_o  = idx_q[AW-1:0];
    wr_data_o  = rd_data_i;
    rd_en_o    = 1'b0;
    rd_addr_o  = mid[AW-1:0];
    out_load_o = 1'b0;
    out_word_o.sorted_value = rd_data_i;
    out_word_o.last_out     = (idx_inc == fill_q);
    out_word_o.overflow     = dropped_q;
    unique case (state_q)
      ST_SRCH_RD: begin
        rd_en_o = (lo_q < hi_q);
      end
      ST_SHF_RD: begin
        if (idx_q > lo_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = idx_dec[AW-1:0];
        end else begin
          wr_en_o   = 1'b1;
          wr_addr_o = lo_q[AW-1:0];
          wr_data_o = val_q;
        end
      end
      ST_SHF_WR: begin
        wr_en_o = 1'b1;
      end
      ST_EMIT_RD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = idx_q[AW-1:0];
      end
      ST_EMIT_LD: begin
        out_load_o = slot_free_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      dropped_q <= 1'b0;
      lo_q      <= '0;
      hi_q      <= '0;
      idx_q     <= '0;
      mid_q     <= '0;
      val_q     <= '0;
      last_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            val_q  <= in_word_i.value;
            last_q <= in_word_i.last_in;
            lo_q   <= '0;
            hi_q   <= fill_q;
            idx_q  <= '0;
            if (fill_q == CW'(DEPTH)) begin
              // store full: drop the word
              dropped_q <= 1'b1;
              state_q   <= in_word_i.last_in ? ST_EMIT_RD : ST_IDLE;
            end else begin
              state_q <= ST_SRCH_RD;
            end
          end
        end
        ST_SRCH_RD: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid[AW-1:0];
            state_q <= ST_SRCH_CMP;
          end else begin
            idx_q   <= fill_q;
            state_q <= ST_SHF_RD;
          end
        end
        ST_SRCH_CMP: begin
          if (key_less) begin
            lo_q <= CW'(mid_q) + CW'(1);
          end else begin
            hi_q <= CW'(mid_q);
          end
          state_q <= ST_SRCH_RD;
        end
        ST_SHF_RD: begin
          if (idx_q > lo_q) begin
            state_q <= ST_SHF_WR;
          end else begin
            fill_q  <= fill_q + CW'(1);
            idx_q   <= '0;
            state_q <= last_q ? ST_EMIT_RD : ST_IDLE;
          end
        end
        ST_SHF_WR: begin
          idx_q   <= idx_dec;
          state_q <= ST_SHF_RD;
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (slot_free_i) begin
            if (idx_inc == fill_q) begin
              fill_q    <= '0;
              dropped_q <= 1'b0;
              idx_q     <= '0;
              state_q   <= ST_IDLE;
            end else begin
              idx_q   <= idx_inc;
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/binary_insertion_sort_engine_top.sv]
// ----------------------------------------------------------------------------
// binary_insertion_sort_engine_top: binary insertion sort engine
// Sorts signed words into ascending order and streams the list out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one signed word
//   per transfer; last_in marks the end of a list. Each word is inserted into
//   a sorted store of DEPTH entries at its lower-bound position.
//   Insertion runs a binary search of S steps (at most ceil(log2(DEPTH)))
//   and then moves up the M entries above the insertion point; the store
//   is read once per compare or move.
//   After the word marked last, the list is read out on the output channel
//   (out_valid_o / out_ready_i / out_data_o), one word at a time, with
//   last_out on the final one and overflow on all of them if words were
//   dropped because the store was full. The input is not ready meanwhile.
//   A result register decouples the sides; a stalled receiver holds the
//   readout. A new list is taken as soon as the last result is registered.
//   Reset empties the list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_insertion_sort_engine_top
  import bise_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bise_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bise_out_t out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic signed [VALUE_W-1:0] rd_data;
  logic                      slot_free;
  logic                      out_load;
  bise_out_t                 out_word;
  logic                      out_valid_q;
  bise_out_t                 out_data_q;

  bise_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bise_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_data_i),
    .slot_free_i (slot_free),
    .out_load_o  (out_load),
    .out_word_o  (out_word),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_out_held_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result word changed while the receiver stalled");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while stalled");

  a_idle_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_word.last_out) |=> in_ready_o)
    else $error("not ready after the final result");

  a_no_input_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !in_ready_o)
    else $error("ready raised during readout");
`endif

endmodule
